### hw/rtl/max_heap_priority_queue_defines.svh
// Assertion macros used by the max-heap priority queue checker.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, muted during reset.
`define MHPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("mhpq: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, muted during reset.
`define MHPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("mhpq: next-cycle check failed");

`endif

### hw/rtl/mhpq_pkg.sv
// Shared types, codes and defaults of the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [STAT_W-1:0]       t_status;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/mhpq_if.sv
// Request and response channel interfaces of the max-heap priority queue.
`default_nettype none

interface mhpq_req_if;
    import mhpq_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    t_value value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mhpq_rsp_if #(
    parameter int CNT_W = 7
);
    import mhpq_pkg::*;

    logic             valid;
    logic             ready;
    t_status          status;
    t_value           removed_value;
    logic [CNT_W-1:0] count;

    modport source (output valid, output status, output removed_value, output count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input count,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/max_heap_priority_queue.sv
// Max-heap priority queue: binary max-heap of signed 32-bit values in one memory.
// Insert walks up one level at a time; remove walks down one level at a time, reading
// the two children in turn through the single read port. At DEPTH 64 the count left
// after a remove is at most 63.
// Ready is high only while idle; a waiting result does not block the next transfer.
// Reset clears the element count and the response valid flag; store contents are
// left as they are, and no clearing pass runs.
`default_nettype none

module max_heap_priority_queue #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);
    import mhpq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_value        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_value        mem_rdata;
    t_value        cmp_a;
    t_value        cmp_b;
    logic          cmp_gt;
    t_value        cmp_max;

    mhpq_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_cmp_a     (cmp_a),
        .o_cmp_b     (cmp_b),
        .i_cmp_gt    (cmp_gt),
        .i_cmp_max   (cmp_max)
    );

    mhpq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mhpq_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_gt  (cmp_gt),
        .o_max (cmp_max)
    );

endmodule

`default_nettype wire

### hw/rtl/mhpq_mem.sv
// Heap store: one write port and one read port with registered read data.
`default_nettype none

module mhpq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire mhpq_pkg::t_value  i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output mhpq_pkg::t_value       o_rdata
);
    import mhpq_pkg::*;

    t_value r_mem [DEPTH];
    t_value r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/mhpq_cmp.sv
// Shared signed compare unit: greater-than flag and the larger operand.
`default_nettype none

module mhpq_cmp (
    input  wire mhpq_pkg::t_value i_a,
    input  wire mhpq_pkg::t_value i_b,
    output logic                  o_gt,
    output mhpq_pkg::t_value      o_max
);
    import mhpq_pkg::*;

    // Strict signed compare; ties keep operand b
    assign o_gt  = (i_a > i_b);
    assign o_max = o_gt ? i_a : i_b;

endmodule

`default_nettype wire

### hw/rtl/mhpq_ctrl.sv
// Sequencer that walks the heap one level at a time and holds the response.
`default_nettype none

module mhpq_ctrl #(
    parameter int DEPTH = 64,
    parameter int CW    = 7,
    parameter int AW    = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mhpq_req_if.sink               i_req,
    mhpq_rsp_if.source             o_rsp,
    // Memory port
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output mhpq_pkg::t_value       o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  wire mhpq_pkg::t_value  i_mem_rdata,
    // Compare unit
    output mhpq_pkg::t_value       o_cmp_a,
    output mhpq_pkg::t_value       o_cmp_b,
    input  wire logic              i_cmp_gt,
    input  wire mhpq_pkg::t_value  i_cmp_max
);
    import mhpq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP      = 3'd1;
    localparam logic [2:0] S_FIN     = 3'd2;
    localparam logic [2:0] S_RM_ROOT = 3'd3;
    localparam logic [2:0] S_RM_LAST = 3'd4;
    localparam logic [2:0] S_DN_L    = 3'd5;
    localparam logic [2:0] S_DN_R    = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] POS_ROOT = CW'(1);

    // Heap position (1-based) to store slot
    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] pos);
        logic [CW-1:0] t;
        t = pos - POS_ROOT;
        return t[AW-1:0];
    endfunction

    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_pos, n_pos;
    t_value         r_cur, n_cur;
    t_value         r_best, n_best;
    logic           r_best_l, n_best_l;
    t_status        r_status, n_status;
    t_value         r_rem, n_rem;
    logic           r_ovalid, n_ovalid;
    t_status        r_ostatus, n_ostatus;
    t_value         r_orem, n_orem;
    logic [CW-1:0]  r_ocnt, n_ocnt;

    logic [CW:0]    w_cnt_ext;
    logic [CW:0]    w_l;
    logic [CW:0]    w_r;
    logic           w_has_r;
    logic [CW-1:0]  w_cnt_inc;
    logic [CW-1:0]  w_par;
    logic [CW:0]    w_lp;
    logic           w_descend;

    assign w_cnt_ext = {1'b0, r_cnt};
    assign w_l       = {r_pos, 1'b0};
    assign w_r       = {r_pos, 1'b1};
    assign w_has_r   = (w_r <= w_cnt_ext);
    assign w_cnt_inc = r_cnt + POS_ROOT;
    assign w_par     = r_pos >> 1;

    // Next-state and datapath control
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_best      = r_best;
        n_best_l    = r_best_l;
        n_status    = r_status;
        n_rem       = r_rem;
        n_ovalid    = r_ovalid & ~o_rsp.ready;
        n_ostatus   = r_ostatus;
        n_orem      = r_orem;
        n_ocnt      = r_ocnt;
        o_mem_we    = 1'b0;
        o_mem_waddr = slot_of(r_pos);
        o_mem_wdata = r_cur;
        o_mem_raddr = '0;
        o_cmp_a     = r_cur;
        o_cmp_b     = i_mem_rdata;
        w_descend   = 1'b0;
        w_lp        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_rem    = '0;
                    n_status = ST_OK;
                    if (i_req.req_type == REQ_INSERT) begin
                        if (r_cnt == CNT_FULL) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_cnt = w_cnt_inc;
                            n_pos = w_cnt_inc;
                            n_cur = i_req.value;
                            if (r_cnt == '0) begin
                                n_state = S_FIN;
                            end else begin
                                o_mem_raddr = slot_of(w_cnt_inc >> 1);
                                n_state     = S_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            o_mem_raddr = slot_of(POS_ROOT);
                            n_state     = S_RM_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                // Parent value is on the read port; move it down if smaller
                o_cmp_a = r_cur;
                o_cmp_b = i_mem_rdata;
                o_mem_we = 1'b1;
                if (i_cmp_gt) begin
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = w_par;
                    if (w_par == POS_ROOT) begin
                        n_state = S_FIN;
                    end else begin
                        o_mem_raddr = slot_of(w_par >> 1);
                    end
                end else begin
                    o_mem_wdata = r_cur;
                    n_state     = S_OUT;
                end
            end
            S_FIN: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = r_cur;
                n_state     = S_OUT;
            end
            S_RM_ROOT: begin
                n_rem       = i_mem_rdata;
                o_mem_raddr = slot_of(r_cnt);
                n_cnt       = r_cnt - POS_ROOT;
                n_state     = S_RM_LAST;
            end
            S_RM_LAST: begin
                n_cur = i_mem_rdata;
                n_pos = POS_ROOT;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    w_descend = 1'b1;
                end
            end
            S_DN_L: begin
                // Left child against the moving element
                o_cmp_a = i_mem_rdata;
                o_cmp_b = r_cur;
                if (w_has_r) begin
                    n_best      = i_cmp_max;
                    n_best_l    = i_cmp_gt;
                    o_mem_raddr = slot_of(w_r[CW-1:0]);
                    n_state     = S_DN_R;
                end else begin
                    o_mem_we = 1'b1;
                    if (i_cmp_gt) begin
                        o_mem_wdata = i_mem_rdata;
                        n_pos       = w_l[CW-1:0];
                        w_descend   = 1'b1;
                    end else begin
                        o_mem_wdata = r_cur;
                        n_state     = S_OUT;
                    end
                end
            end
            S_DN_R: begin
                // Right child against the larger of left child and element
                o_cmp_a  = i_mem_rdata;
                o_cmp_b  = r_best;
                o_mem_we = 1'b1;
                if (i_cmp_gt) begin
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = w_r[CW-1:0];
                    w_descend   = 1'b1;
                end else if (r_best_l) begin
                    o_mem_wdata = r_best;
                    n_pos       = w_l[CW-1:0];
                    w_descend   = 1'b1;
                end else begin
                    o_mem_wdata = r_cur;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_orem    = r_rem;
                    n_ocnt    = r_cnt;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Start the next level down: fetch the left child or settle here
        if (w_descend) begin
            w_lp = {n_pos, 1'b0};
            if (w_lp <= w_cnt_ext) begin
                o_mem_raddr = slot_of(w_lp[CW-1:0]);
                n_state     = S_DN_L;
            end else begin
                n_state = S_FIN;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_cur     <= n_cur;
        r_best    <= n_best;
        r_best_l  <= n_best_l;
        r_status  <= n_status;
        r_rem     <= n_rem;
        r_ostatus <= n_ostatus;
        r_orem    <= n_orem;
        r_ocnt    <= n_ocnt;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_ostatus;
    assign o_rsp.removed_value = r_orem;
    assign o_rsp.count         = r_ocnt;

endmodule

`default_nettype wire

### hw/rtl/mhpq_checker.sv
// Port-level checker of the max-heap priority queue and its bind.
`default_nettype none

`include "max_heap_priority_queue_defines.svh"

module mhpq_checker #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire mhpq_pkg::t_status i_rsp_status,
    input wire mhpq_pkg::t_value  i_rsp_removed_value,
    input wire logic [CW-1:0]     i_rsp_count
);
    import mhpq_pkg::*;

    // Hold a stalled response
    `MHPQ_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_removed_value) && $stable(i_rsp_count))

    // Not ready in the cycle after each request transfer
    `MHPQ_ASSERT_NXT(a_busy_after_req, i_req_valid && i_req_ready, !i_req_ready)

    // Rejected requests return no value
    `MHPQ_ASSERT_NOW(a_err_no_value, i_rsp_valid && (i_rsp_status != ST_OK), i_rsp_removed_value == '0)

    // Empty status only with nothing held
    `MHPQ_ASSERT_NOW(a_empty_count, i_rsp_valid && (i_rsp_status == ST_EMPTY), i_rsp_count == '0)

    // Full status only with the store full
    `MHPQ_ASSERT_NOW(a_full_count, i_rsp_valid && (i_rsp_status == ST_FULL), i_rsp_count == CW'(DEPTH))

endmodule

bind max_heap_priority_queue mhpq_checker #(
    .DEPTH (DEPTH)
) u_mhpq_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_removed_value (o_rsp.removed_value),
    .i_rsp_count         (o_rsp.count)
);

`default_nettype wire
